>>> hdl/ihls_pkg.sv
// Shared types, constants and lookup functions for the RGB to IHLS pixel converter.
package ihls_pkg;

  localparam int CORDIC_STAGES  = 16;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int N_ITER = (CORDIC_STAGES < ATAN_TABLE_LEN) ? CORDIC_STAGES : ATAN_TABLE_LEN;
  localparam int IDX_W  = $clog2(ATAN_TABLE_LEN);

  localparam int Q_FRAC = 16;
  localparam int XY_W   = 28;   // signed Q16 vector, covers CORDIC gain
  localparam int Z_W    = 20;   // signed Q16 radians
  localparam int ZW_W   = 19;   // wrapped angle, 0 .. 2*pi
  localparam int ATAN_W = 17;

  localparam int SQRT3_Q16   = 113512;
  localparam int HALF_PI_Q16 = 102944;
  localparam int PI_Q16      = 205887;
  localparam int TWO_PI_Q16  = 411775;

  localparam logic signed [18:0]    SQRT3_C   = 19'(SQRT3_Q16);
  localparam logic signed [Z_W-1:0] HALF_PI_Z = Z_W'(HALF_PI_Q16);
  localparam logic signed [Z_W-1:0] PI_Z      = Z_W'(PI_Q16);
  localparam logic signed [Z_W-1:0] TWO_PI_Z  = Z_W'(TWO_PI_Q16);

  // hue = floor(z * 255 / 2pi) via reciprocal, then one correction step
  localparam int HUE_SHIFT   = 32;
  localparam int HUE_RECIP_W = 22;
  localparam longint HUE_RECIP_L = (longint'(255) << HUE_SHIFT) / TWO_PI_Q16;
  localparam logic [HUE_RECIP_W-1:0] HUE_RECIP = HUE_RECIP_W'(HUE_RECIP_L);
  localparam int NUM_W  = ZW_W + 8;
  localparam int PROD_W = ZW_W + HUE_RECIP_W;
  localparam logic [NUM_W-1:0] TWO_PI_N = NUM_W'(TWO_PI_Q16);

  // sat/lum delay line depth, and the accept-to-done latency of the pixel pipeline
  localparam int LUM_DELAY = N_ITER + 3;
  localparam int LATENCY   = N_ITER + 5;

  typedef struct packed {
    logic                   valid;
    logic                   gray;
    logic                   upper;   // y0 >= 0
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic [7:0] sat;
    logic [7:0] lum;
  } tone_t;

  function automatic logic [ATAN_W-1:0] atan_q16(input logic [IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 17'd51472;
      5'd1:    v = 17'd30385;
      5'd2:    v = 17'd16055;
      5'd3:    v = 17'd8150;
      5'd4:    v = 17'd4091;
      5'd5:    v = 17'd2047;
      5'd6:    v = 17'd1024;
      5'd7:    v = 17'd512;
      5'd8:    v = 17'd256;
      5'd9:    v = 17'd128;
      5'd10:   v = 17'd64;
      5'd11:   v = 17'd32;
      5'd12:   v = 17'd16;
      5'd13:   v = 17'd8;
      5'd14:   v = 17'd4;
      5'd15:   v = 17'd2;
      5'd16:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/rgb_to_ihls_pixel.sv
// RGB to IHLS pixel converter: one pixel in and one out every clock.
// Pipeline from accept to done: one vector setup stage, one stage per CORDIC
// iteration, four hue scaling stages; saturation and luminance run alongside.
// Throughput: one pixel per cycle, busy is always low; done pulses for one cycle.
// Synchronous active-high reset clears the pipeline valid bits only.
module rgb_to_ihls_pixel
  import ihls_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       done,
  output logic [7:0] saturation,
  output logic [7:0] luminance,
  output logic [7:0] hue
);

  logic load;
  assign busy = 1'b0;
  assign load = start && !busy;

  tone_t tone;
  tone_t tone_dly [LUM_DELAY];

  ihls_tone u_tone (
    .clk   (clk),
    .red   (red),
    .green (green),
    .blue  (blue),
    .tone  (tone)
  );

  always_ff @(posedge clk) begin
    tone_dly[0] <= tone;
    for (int i = 1; i < LUM_DELAY; i++) begin
      tone_dly[i] <= tone_dly[i-1];
    end
  end

  cordic_t cstage [N_ITER+1];

  ihls_prerot u_prerot (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .red   (red),
    .green (green),
    .blue  (blue),
    .c_out (cstage[0])
  );

  for (genvar g = 0; g < N_ITER; g++) begin : g_cordic
    ihls_cordic_stage u_stage (
      .clk   (clk),
      .rst   (rst),
      .idx   (IDX_W'(g)),
      .c_in  (cstage[g]),
      .c_out (cstage[g+1])
    );
  end

  ihls_hue_scale u_scale (
    .clk   (clk),
    .rst   (rst),
    .c_in  (cstage[N_ITER]),
    .valid (done),
    .hue   (hue)
  );

  assign saturation = tone_dly[LUM_DELAY-1].sat;
  assign luminance  = tone_dly[LUM_DELAY-1].lum;

endmodule

>>> hdl/ihls_tone.sv
// Saturation and luminance path: two register stages.
module ihls_tone
  import ihls_pkg::*;
(
  input  logic       clk,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output tone_t      tone
);

  logic [7:0]  mx, mn;
  logic [7:0]  sat_a;
  logic [23:0] pr, pg, pb;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
  end

  always_ff @(posedge clk) begin
    sat_a <= mx - mn;
    pr    <= 24'(red)   * 24'd13763;
    pg    <= 24'(green) * 24'd46858;
    pb    <= 24'(blue)  * 24'd4719;
  end

  logic [23:0] lsum;
  assign lsum = pr + pg + pb;

  always_ff @(posedge clk) begin
    tone.sat <= sat_a;
    tone.lum <= lsum[23:16];
  end

endmodule

>>> hdl/ihls_prerot.sv
// Builds the Q16 hue vector from the pixel and turns it into the right half plane.
module ihls_prerot
  import ihls_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output cordic_t    c_out
);

  logic signed [10:0]     d;
  logic signed [9:0]      e;
  logic signed [XY_W-1:0] x0, y0;
  cordic_t                c_next;

  always_comb begin
    d  = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green}) - $signed({3'b000, blue});
    e  = $signed({2'b00, green}) - $signed({2'b00, blue});
    x0 = XY_W'(d) <<< Q_FRAC;
    y0 = XY_W'(e) * XY_W'(SQRT3_C);

    c_next.valid = load;
    c_next.gray  = (red == green) && (green == blue);
    c_next.upper = !y0[XY_W-1];
    c_next.x     = x0;
    c_next.y     = y0;
    c_next.z     = '0;
    if (x0 < 0) begin
      if (!y0[XY_W-1]) begin
        c_next.x = y0;
        c_next.y = -x0;
        c_next.z = HALF_PI_Z;
      end else begin
        c_next.x = -y0;
        c_next.y = x0;
        c_next.z = -HALF_PI_Z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_out.valid <= 1'b0;
    end else begin
      c_out.valid <= c_next.valid;
    end
    c_out.gray  <= c_next.gray;
    c_out.upper <= c_next.upper;
    c_out.x     <= c_next.x;
    c_out.y     <= c_next.y;
    c_out.z     <= c_next.z;
  end

endmodule

>>> hdl/ihls_cordic_stage.sv
// One registered CORDIC vectoring iteration.
module ihls_cordic_stage
  import ihls_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  cordic_t          c_in,
  output cordic_t          c_out
);

  logic signed [XY_W-1:0] xi, yi, xs, ys;
  logic signed [Z_W-1:0]  ang;
  cordic_t                c_next;

  always_comb begin
    xi  = c_in.x;
    yi  = c_in.y;
    xs  = xi >>> idx;   // arithmetic, floors
    ys  = yi >>> idx;
    ang = $signed({{(Z_W-ATAN_W){1'b0}}, atan_q16(idx)});
    c_next = c_in;
    if (!yi[XY_W-1]) begin
      c_next.x = xi + ys;
      c_next.y = yi - xs;
      c_next.z = c_in.z + ang;
    end else begin
      c_next.x = xi - ys;
      c_next.y = yi + xs;
      c_next.z = c_in.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_out.valid <= 1'b0;
    end else begin
      c_out.valid <= c_next.valid;
    end
    c_out.gray  <= c_next.gray;
    c_out.upper <= c_next.upper;
    c_out.x     <= c_next.x;
    c_out.y     <= c_next.y;
    c_out.z     <= c_next.z;
  end

endmodule

>>> hdl/ihls_hue_scale.sv
// Clamps and wraps the CORDIC angle, then scales it to 0..255 over four stages.
module ihls_hue_scale
  import ihls_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cordic_t    c_in,
  output logic       valid,
  output logic [7:0] hue
);

  logic signed [Z_W-1:0] zc, zwr;

  // keep residue from crossing the real axis
  always_comb begin
    zc = c_in.z;
    if (c_in.upper) begin
      if (c_in.z < 0)         zc = '0;
      else if (c_in.z > PI_Z) zc = PI_Z;
    end else begin
      if (c_in.z > -1)         zc = Z_W'(-1);
      else if (c_in.z < -PI_Z) zc = -PI_Z;
    end
    zwr = (zc < 0) ? zc + TWO_PI_Z : zc;
  end

  logic [2:0]        vld;
  logic [2:0]        gry;
  logic [ZW_W-1:0]   zw;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  num_b, num_c, qm;
  logic [7:0]        q0;
  logic [NUM_W-1:0]  rem;

  assign rem = num_c - qm;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      valid <= 1'b0;
    end else begin
      vld   <= {vld[1:0], c_in.valid};
      valid <= vld[2];
    end
    gry   <= {gry[1:0], c_in.gray};
    zw    <= zwr[ZW_W-1:0];
    prod  <= PROD_W'(zw) * PROD_W'(HUE_RECIP);
    num_b <= NUM_W'(zw) * NUM_W'(255);
    q0    <= prod[HUE_SHIFT +: 8];
    qm    <= NUM_W'(prod[HUE_SHIFT +: 8]) * TWO_PI_N;
    num_c <= num_b;
    // estimate is exact or one low
    if (gry[2])                hue <= '0;
    else if (rem >= TWO_PI_N)  hue <= q0 + 8'd1;
    else                       hue <= q0;
  end

endmodule

>>> hdl/ihls_checker.sv
// Port-level checks for the RGB to IHLS converter, bound to the top level.
module ihls_checker
  import ihls_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       done,
  input logic [7:0] saturation,
  input logic [7:0] luminance,
  input logic [7:0] hue
);

  // every accepted beat comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted beat not delivered after fixed latency");

  // no result without a matching accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe with no accepted beat");

  // gray pixel gives zero hue and zero saturation
  a_gray: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && red == green && green == blue)
      |-> ##LATENCY (hue == 8'd0 && saturation == 8'd0))
    else $error("gray pixel gave nonzero hue or saturation");

  // the weighted sum stays below full scale
  a_lum_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (luminance != 8'd255))
    else $error("luminance out of range");

endmodule

bind rgb_to_ihls_pixel ihls_checker u_ihls_checker (.*);

>>> tb/sv/rgb_to_ihls_pixel_test.sv
// Self-checking testbench for the RGB to IHLS pixel converter.
`timescale 1ns / 1ps

module rgb_to_ihls_pixel_test;
  import ihls_pkg::*;

  localparam int RANDOM_PIXELS = 1300;
  localparam int QUIET_TAIL    = 200;   // last pixels go back to back
  localparam int STALL_LIMIT   = 1000;  // cycles with no beat on either side

  typedef struct packed {
    logic [7:0] sat;
    logic [7:0] lum;
    logic [7:0] hue;
  } ihls_pix_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       typed;   // use the literal values below instead of the predictor
    ihls_pix_t  want;
  } pixel_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [7:0] red = 8'd0;
  logic [7:0] green = 8'd0;
  logic [7:0] blue = 8'd0;
  logic       busy;
  logic       done;
  logic [7:0] saturation;
  logic [7:0] luminance;
  logic [7:0] hue;

  ihls_pix_t  pending_pix = '0;   // expectation for the pixel now on the inputs
  ihls_pix_t  expected_pixels[$];
  ihls_pix_t  got_pix;
  int         fail_count = 0;
  int         stall_cycles = 0;
  bit         timed_out = 1'b0;

  // atan(2^-i) in Q16 radians
  longint arctan_q16 [0:23] = '{
    51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  rgb_to_ihls_pixel uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .red(red),
    .green(green),
    .blue(blue),
    .done(done),
    .saturation(saturation),
    .luminance(luminance),
    .hue(hue)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] hue_angle(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    longint rl, gl, bl, x, y, y0, z, t, xs, ys;
    int i;
    rl = longint'(r);
    gl = longint'(g);
    bl = longint'(b);
    if (rl == gl && gl == bl) return 8'd0;
    x = (2 * rl - gl - bl) * 65536;
    y = (gl - bl) * longint'(SQRT3_Q16);
    y0 = y;
    z = 0;
    // left half plane: turn by a quarter so CORDIC starts in range
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = HALF_PI_Q16;
      end else begin
        x = -y;
        y = t;
        z = -HALF_PI_Q16;
      end
    end
    for (i = 0; i < N_ITER; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_q16[i];
      end
    end
    if (y0 >= 0) begin
      if (z < 0) z = 0;
      if (z > PI_Q16) z = PI_Q16;
    end else begin
      if (z > -1) z = -1;
      if (z < -PI_Q16) z = -PI_Q16;
    end
    if (z < 0) z = z + TWO_PI_Q16;
    t = (z * 255) / TWO_PI_Q16;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  function automatic ihls_pix_t ihls_of(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    ihls_pix_t p;
    logic [7:0] hi, lo;
    longint wsum;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    wsum = (13763 * longint'(r) + 46858 * longint'(g) + 4719 * longint'(b)) >>> 16;
    p.sat = hi - lo;
    p.lum = wsum[7:0];
    p.hue = hue_angle(r, g, b);
    return p;
  endfunction

  function automatic pixel_row_t pix_row(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic typed,
                                         input logic [7:0] s, input logic [7:0] l,
                                         input logic [7:0] h);
    pixel_row_t row;
    row.r = r;
    row.g = g;
    row.b = b;
    row.typed = typed;
    row.want = '{sat: s, lum: l, hue: h};
    return row;
  endfunction

  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // pick 0, 255 or a random byte
  function automatic logic [7:0] edge_byte();
    case ($urandom_range(0, 2))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input pixel_row_t row);
    @(negedge clk);
    red <= row.r;
    green <= row.g;
    blue <= row.b;
    pending_pix <= row.typed ? row.want : ihls_of(row.r, row.g, row.b);
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      red <= 8'($urandom);
      green <= 8'($urandom);
      blue <= 8'($urandom);
    end
  endtask

  // scoreboard: check the result beat, then record the input beat
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (done) begin
        got_pix = '{sat: saturation, lum: luminance, hue: hue};
        if (expected_pixels.size() == 0) begin
          $error("unexpected result beat: sat %0d lum %0d hue %0d",
                 saturation, luminance, hue);
          fail_count++;
        end else begin
          ihls_pix_t want;
          want = expected_pixels.pop_front();
          if (got_pix.sat !== want.sat) begin
            $error("saturation: expected %0d, got %0d", want.sat, got_pix.sat);
            fail_count++;
          end
          if (got_pix.lum !== want.lum) begin
            $error("luminance: expected %0d, got %0d", want.lum, got_pix.lum);
            fail_count++;
          end
          if (got_pix.hue !== want.hue) begin
            $error("hue: expected %0d, got %0d", want.hue, got_pix.hue);
            fail_count++;
          end
        end
      end
      if (start && !busy) expected_pixels.push_back(pending_pix);
      if (done || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    pixel_row_t directed_rows[$];
    pixel_row_t row;
    int v, idle_odds;

    // gray pixels have a fixed answer; the rest go through the predictor
    directed_rows.push_back(pix_row(8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 8'd254, 8'd0));
    directed_rows.push_back(pix_row(8'd128, 8'd128, 8'd128, 1'b1, 8'd0, 8'd127, 8'd0));
    directed_rows.push_back(pix_row(8'd1, 8'd1, 8'd1, 1'b1, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd255, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd0, 8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd0, 8'd0, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd255, 8'd255, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd0, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd255, 8'd0, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0));
    // hue just either side of zero: clamps in both half planes
    directed_rows.push_back(pix_row(8'd255, 8'd1, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd255, 8'd0, 8'd1, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd1, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd0, 8'd1, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd0, 8'd0, 8'd1, 1'b0, 8'd0, 8'd0, 8'd0));
    // negative x with y exactly zero: quarter turn from the upper side
    directed_rows.push_back(pix_row(8'd0, 8'd128, 8'd128, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd0, 8'd1, 8'd1, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd1, 8'd0, 8'd1, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd1, 8'd1, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd254, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd255, 8'd254, 8'd254, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd200, 8'd100, 8'd50, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd10, 8'd250, 8'd130, 1'b0, 8'd0, 8'd0, 8'd0));
    directed_rows.push_back(pix_row(8'd85, 8'd170, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    fork
      begin
        foreach (directed_rows[k]) begin
          send_pixel(directed_rows[k]);
          if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 8));
        end
        idle_odds = 4;
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
          if (n % 64 == 0) idle_odds = $urandom_range(0, 6);
          row = '0;
          case ($urandom_range(0, 9))
            0: begin
              v = $urandom_range(0, 255);
              row.r = v[7:0];
              row.g = v[7:0];
              row.b = v[7:0];
            end
            1, 2: begin
              // near gray: small hue vectors stress the CORDIC residue
              v = $urandom_range(0, 255);
              row.r = clamp_byte(v + $urandom_range(0, 4) - 2);
              row.g = clamp_byte(v + $urandom_range(0, 4) - 2);
              row.b = clamp_byte(v + $urandom_range(0, 4) - 2);
            end
            3: begin
              row.r = edge_byte();
              row.g = edge_byte();
              row.b = edge_byte();
            end
            default: begin
              row.r = 8'($urandom);
              row.g = 8'($urandom);
              row.b = 8'($urandom);
            end
          endcase
          send_pixel(row);
          if (n < RANDOM_PIXELS - QUIET_TAIL && idle_odds != 0 &&
              $urandom_range(1, idle_odds + 2) == 1)
            idle_gap($urandom_range(1, 8));
        end
        @(negedge clk);
        start <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
      end
      begin
        while (stall_cycles < STALL_LIMIT) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any
    disable fork;

    if (!timed_out && fail_count == 0 && expected_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
